// ----- hw/rtl/ntr_pkg.sv -----
// Shared types, constants and register codes for the tile rewrite unit.
package ntr_pkg;

    localparam int TILE_W           = 8;
    localparam int MAP_W            = 7;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 8;
    localparam int DEFAULT_MAX_SIDE = 64;
    localparam int MAP_SIZE_RESET   = 64;
    localparam int NBR_N            = 8;

    typedef logic [TILE_W-1:0] tile_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_TARGET      = 3'd1,
        REG_NEIGHBOR    = 3'd2,
        REG_REPLACEMENT = 3'd3,
        REG_MAP_SIZE    = 3'd4
    } cfg_reg_t;

    // neighbour slots within the window
    localparam int NB_TL = 0;
    localparam int NB_T  = 1;
    localparam int NB_TR = 2;
    localparam int NB_L  = 3;
    localparam int NB_R  = 4;
    localparam int NB_BL = 5;
    localparam int NB_B  = 6;
    localparam int NB_BR = 7;

    typedef struct packed {
        logic  mode;
        tile_t target;
        tile_t neighbor;
        tile_t replacement;
    } rule_t;

    typedef struct packed {
        tile_t                   centre;
        tile_t [NBR_N-1:0]       nbr;
        logic  [NBR_N-1:0]       nbr_ok;
    } window_t;

endpackage

// ----- hw/rtl/neighbor_conditioned_tile_rewrite_unit.sv -----
// Top level of the 3x3 neighbour-conditioned tile rewrite unit.
// Latency: the result for tile p is computed on the word side+1 places later and is
//   shown on the m_ side in the cycle after that word is accepted.
// Throughput: one word per cycle while m_ready is high; window compare and line shift
//   finish on acceptance, and the output register drains while the next word enters.
// Reset (aresetn low, synchronous): positions, output valid and config registers return to
//   their reset values; the line cells are not cleared, as stale tiles are masked.
module neighbor_conditioned_tile_rewrite_unit
    import ntr_pkg::*;
#(
    parameter int MAX_SIDE = DEFAULT_MAX_SIDE
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tile_t                s_tile_code,
    input  logic                 s_pad,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output tile_t                m_result_tile,
    output logic                 m_last_tile
);

    // side length, stream position and column/row widths
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int PW    = $clog2(MAX_SIDE * MAX_SIDE + MAX_SIDE + 2);
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int CMP_W = (SW > MAP_W) ? SW : MAP_W;
    localparam int RST_SIDE   = (MAX_SIDE < MAP_SIZE_RESET) ? MAX_SIDE : MAP_SIZE_RESET;
    localparam int RST_STREAM = RST_SIDE * RST_SIDE + RST_SIDE + 1;

    // ---------------------------------------------------------------------------------
    // Configuration. Map size is kept already clamped, with the stream length worked
    // out at write time (map plus side+1 flush words).
    // ---------------------------------------------------------------------------------
    rule_t          rule_reg;
    logic [SW-1:0]  side_reg;
    logic [PW-1:0]  stream_len_reg;

    logic [CMP_W-1:0] map_wide;
    logic [SW-1:0]    side_next;
    logic [2*SW:0]    stream_full;
    logic [PW-1:0]    stream_len_next;

    always_comb begin
        map_wide = CMP_W'(cfg_wdata[MAP_W-1:0]);
        if (map_wide == '0) begin
            side_next = SW'(1);
        end else if (map_wide > CMP_W'(MAX_SIDE)) begin
            side_next = SW'(MAX_SIDE);
        end else begin
            side_next = map_wide[SW-1:0];
        end
        stream_full = (2*SW+1)'(side_next) * (2*SW+1)'(side_next)
                    + (2*SW+1)'(side_next) + (2*SW+1)'(1);
        stream_len_next = stream_full[PW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_reg       <= '0;
            side_reg       <= SW'(RST_SIDE);
            stream_len_reg <= PW'(RST_STREAM);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:        rule_reg.mode        <= cfg_wdata[0];
                REG_TARGET:      rule_reg.target      <= cfg_wdata[TILE_W-1:0];
                REG_NEIGHBOR:    rule_reg.neighbor    <= cfg_wdata[TILE_W-1:0];
                REG_REPLACEMENT: rule_reg.replacement <= cfg_wdata[TILE_W-1:0];
                REG_MAP_SIZE: begin
                    side_reg       <= side_next;
                    stream_len_reg <= stream_len_next;
                end
                default: ;  // unknown index: no register
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Handshake: the output register frees itself in the same cycle it is taken.
    // ---------------------------------------------------------------------------------
    logic  m_valid_reg;
    tile_t m_result_tile_reg;
    logic  m_last_tile_reg;
    logic  accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // ---------------------------------------------------------------------------------
    // Positions. in_pos_reg counts words of the stream; col/row track the tile that
    // leaves next. A map size change that leaves the position past the new stream end
    // restarts the map before the word is taken.
    // ---------------------------------------------------------------------------------
    logic [PW-1:0] in_pos_reg,  in_pos_next;
    logic [CW-1:0] col_reg,     col_next;
    logic [CW-1:0] row_reg,     row_next;

    logic          stale;
    logic [PW-1:0] pos_eff;
    logic [CW-1:0] col_eff, row_eff;
    logic [SW-1:0] side_m1;
    logic          col_end, row_end;
    logic          emit;
    logic          last;

    always_comb begin
        stale   = (in_pos_reg >= stream_len_reg);
        pos_eff = stale ? '0 : in_pos_reg;
        col_eff = stale ? '0 : col_reg;
        row_eff = stale ? '0 : row_reg;
        side_m1 = side_reg - SW'(1);
        col_end = (SW'(col_eff) == side_m1);
        row_end = (SW'(row_eff) == side_m1);
        emit    = (pos_eff > PW'(side_reg));
        last    = col_end && row_end;
    end

    always_comb begin
        in_pos_next = pos_eff + PW'(1);
        col_next    = col_eff;
        row_next    = row_eff;
        if (emit) begin
            if (last) begin
                // end of map: the next word opens a new one
                in_pos_next = '0;
                col_next    = '0;
                row_next    = '0;
            end else if (col_end) begin
                col_next = '0;
                row_next = row_eff + CW'(1);
            end else begin
                col_next = col_eff + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pos_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (accept) begin
            in_pos_reg <= in_pos_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // ---------------------------------------------------------------------------------
    // Window storage. Incoming original tile i arrives as the lower-right neighbour of
    // tile p = i - side - 1.
    //   orig line : originals, head at cell side; cell 0 = centre, cell 1 = right
    //   done line : rewritten tiles, head at cell side; cells 0..2 = upper row
    //   left_reg  : last rewritten tile; lower_*: the two previous originals
    // ---------------------------------------------------------------------------------
    tile_t       code_in;
    tile_t       result;
    tile_t [2:0] orig_taps;
    tile_t [2:0] done_taps;
    tile_t       left_reg;
    tile_t       lower_near_reg;   // original tile i-1: below
    tile_t       lower_far_reg;    // original tile i-2: below-left

    assign code_in = s_pad ? '0 : s_tile_code;

    ntr_line #(
        .DEPTH (MAX_SIDE + 1),
        .SEL_W (SW)
    ) u_orig_line (
        .aclk     (aclk),
        .shift_en (accept),
        .inj_sel  (side_reg),
        .inj_data (code_in),
        .taps     (orig_taps)
    );

    ntr_line #(
        .DEPTH (MAX_SIDE + 1),
        .SEL_W (SW)
    ) u_done_line (
        .aclk     (aclk),
        .shift_en (accept),
        .inj_sel  (side_reg),
        .inj_data (result),
        .taps     (done_taps)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            left_reg       <= result;
            lower_near_reg <= code_in;
            lower_far_reg  <= lower_near_reg;
        end
    end

    // in-map masks for the eight neighbours
    window_t win;
    logic    has_left, has_right, has_up, has_down;

    always_comb begin
        has_left  = (col_eff != '0);
        has_right = !col_end;
        has_up    = (row_eff != '0);
        has_down  = !row_end;

        win.centre     = orig_taps[0];
        win.nbr[NB_TL] = done_taps[0];
        win.nbr[NB_T]  = done_taps[1];
        win.nbr[NB_TR] = done_taps[2];
        win.nbr[NB_L]  = left_reg;
        win.nbr[NB_R]  = orig_taps[1];
        win.nbr[NB_BL] = lower_far_reg;
        win.nbr[NB_B]  = lower_near_reg;
        win.nbr[NB_BR] = code_in;

        win.nbr_ok[NB_TL] = has_up && has_left;
        win.nbr_ok[NB_T]  = has_up;
        win.nbr_ok[NB_TR] = has_up && has_right;
        win.nbr_ok[NB_L]  = has_left;
        win.nbr_ok[NB_R]  = has_right;
        win.nbr_ok[NB_BL] = has_down && has_left;
        win.nbr_ok[NB_B]  = has_down;
        win.nbr_ok[NB_BR] = has_down && has_right;
    end

    ntr_decide u_decide (
        .win    (win),
        .rule   (rule_reg),
        .result (result)
    );

    // ---------------------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_result_tile_reg <= result;
            m_last_tile_reg   <= last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_tile = m_result_tile_reg;
    assign m_last_tile   = m_last_tile_reg;

endmodule

// ----- hw/rtl/ntr_cell.sv -----
// One delay-line cell: holds a tile, loads from its neighbour or from the inject bus.
module ntr_cell
    import ntr_pkg::*;
#(
    parameter int SEL_W = 7,
    parameter int IDX   = 0
) (
    input  logic             aclk,
    input  logic             shift_en,
    input  logic [SEL_W-1:0] inj_sel,
    input  tile_t            inj_data,
    input  tile_t            from_next,
    output tile_t            tile_q
);

    tile_t tile_reg;
    tile_t tile_next;

    // this cell is the head of the line when the side length points here
    always_comb begin
        tile_next = (inj_sel == SEL_W'(IDX)) ? inj_data : from_next;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            tile_reg <= tile_next;
        end
    end

    assign tile_q = tile_reg;

endmodule

// ----- hw/rtl/ntr_line.sv -----
// Row of cells forming a line delay whose length follows the map side.
module ntr_line
    import ntr_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_SIDE + 1,
    parameter int SEL_W = $clog2(DEFAULT_MAX_SIDE + 1)
) (
    input  logic             aclk,
    input  logic             shift_en,
    input  logic [SEL_W-1:0] inj_sel,
    input  tile_t            inj_data,
    output tile_t [2:0]      taps
);

    tile_t chain [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == DEPTH - 1) begin : g_end
            ntr_cell #(
                .SEL_W (SEL_W),
                .IDX   (k)
            ) u_cell (
                .aclk      (aclk),
                .shift_en  (shift_en),
                .inj_sel   (inj_sel),
                .inj_data  (inj_data),
                .from_next (inj_data),
                .tile_q    (chain[k])
            );
        end else begin : g_mid
            ntr_cell #(
                .SEL_W (SEL_W),
                .IDX   (k)
            ) u_cell (
                .aclk      (aclk),
                .shift_en  (shift_en),
                .inj_sel   (inj_sel),
                .inj_data  (inj_data),
                .from_next (chain[k+1]),
                .tile_q    (chain[k])
            );
        end
    end

    assign taps[0] = chain[0];
    assign taps[1] = chain[1];
    assign taps[2] = chain[2];

endmodule

// ----- hw/rtl/ntr_decide.sv -----
// Window test: neighbour match over the in-map slots and the replace decision.
module ntr_decide
    import ntr_pkg::*;
(
    input  window_t win,
    input  rule_t   rule,
    output tile_t   result
);

    logic [NBR_N-1:0] hit;
    logic             found;
    logic             replace;

    always_comb begin
        for (int k = 0; k < NBR_N; k++) begin
            hit[k] = win.nbr_ok[k] && (win.nbr[k] == rule.neighbor);
        end
        found   = |hit;
        replace = (win.centre == rule.target) && (rule.mode ? found : !found);
        result  = replace ? rule.replacement : win.centre;
    end

endmodule
